### sv/ltsrgb_pkg.sv
// shared constants, types and the threshold table builder for the srgb encoder
`timescale 1ns / 1ps

package ltsrgb_pkg;

  // widths fixed by the pixel format
  localparam int IN_W          = 18;
  localparam int BYTE_W        = 8;
  localparam int NUM_CODES     = 1 << BYTE_W;
  localparam int STAGES        = BYTE_W;
  localparam int FRAC_BITS_DEF = 16;

  // thresholds never exceed 2^(IN_W-1), so IN_W unsigned bits hold them
  localparam int THR_W = IN_W;
  // wide enough for x^5 * 10761^12 and (40k+561)^12 * 2^(5*24)
  localparam int BIG_W = 320;

  typedef logic [NUM_CODES-1:0][THR_W-1:0] thr_tab_t;

  // smallest input that reaches each code k, evaluated exactly at elaboration
  // entry 0 is never looked up
  function automatic thr_tab_t build_thr(input int frac_bits);
    thr_tab_t         tab;
    longint           one_v;
    longint           cap;
    longint           lin_lim;
    longint           lin_den;
    longint           lin_max;
    longint           lin_top;
    longint           lo;
    longint           hi;
    longint           mid;
    logic [BIG_W-1:0] c12;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] xb;
    int               k;
    int               i;
    tab     = '0;
    one_v   = longint'(1) << frac_bits;
    cap     = (one_v < (longint'(1) << (IN_W - 1))) ? one_v : (longint'(1) << (IN_W - 1));
    // last input of the linear segment: largest x with x * 10^7 <= 31308 * 2^frac_bits
    lin_lim = longint'(31308) << frac_bits;
    lo      = 0;
    hi      = longint'(1) << IN_W;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * longint'(10000000) <= lin_lim) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    lin_max = lo;
    // highest code the linear segment produces
    lin_den = longint'(100) << frac_bits;
    lin_top = 0;
    for (k = 1; k < NUM_CODES; k++) begin
      if (longint'(k) * lin_den <= longint'(329460) * lin_max) begin
        lin_top = longint'(k);
      end
    end
    c12     = BIG_W'(1);
    for (i = 0; i < 12; i++) begin
      c12 = c12 * BIG_W'(10761);
    end
    for (k = 1; k < NUM_CODES; k++) begin
      if (longint'(k) <= lin_top) begin
        // smallest x with 329460 * x >= k * 100 * 2^frac_bits
        lo = 1;
        hi = lin_max;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (longint'(329460) * mid >= longint'(k) * lin_den) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        tab[k] = THR_W'(lo);
      end else begin
        rhs = BIG_W'(1);
        for (i = 0; i < 12; i++) begin
          rhs = rhs * BIG_W'(40 * k + 561);
        end
        rhs = rhs << (5 * frac_bits);
        lo  = lin_max + 1;
        hi  = cap;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          xb  = BIG_W'(mid);
          lhs = xb * xb * xb * xb * xb * c12;
          if (lhs >= rhs) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        tab[k] = THR_W'(lo);
      end
    end
    return tab;
  endfunction

endpackage

### sv/ltsrgb_lane.sv
// one color lane: pipelined binary search of the input against the code thresholds
`timescale 1ns / 1ps

module ltsrgb_lane #(
  parameter int FRAC_BITS = ltsrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic [ltsrgb_pkg::STAGES-1:0]       en_i,
  input  logic signed [ltsrgb_pkg::IN_W-1:0]  x_i,
  output logic [ltsrgb_pkg::BYTE_W-1:0]       byte_o
);

  localparam int Stages = ltsrgb_pkg::STAGES;
  localparam int InW    = ltsrgb_pkg::IN_W;
  localparam int ByteW  = ltsrgb_pkg::BYTE_W;

  localparam ltsrgb_pkg::thr_tab_t Thr = ltsrgb_pkg::build_thr(FRAC_BITS);

  logic signed [InW-1:0] x_q [Stages-1];
  logic [ByteW-1:0]      b_q [Stages];

  for (genvar j = 0; j < Stages; j++) begin : g_st
    localparam logic [ByteW-1:0] BitMask = ByteW'(1) << (ByteW - 1 - j);

    logic signed [InW-1:0] x_in;
    logic [ByteW-1:0]      b_in;
    logic [ByteW-1:0]      cand;
    logic                  pass;

    if (j == 0) begin : g_first
      assign x_in = x_i;
      assign b_in = '0;
    end else begin : g_next
      assign x_in = x_q[j-1];
      assign b_in = b_q[j-1];
    end

    assign cand = b_in | BitMask;
    // signed compare, thresholds are positive
    assign pass = $signed({x_in[InW-1], x_in}) >= $signed({1'b0, Thr[cand]});

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        b_q[j] <= pass ? cand : b_in;
      end
    end

    if (j < Stages - 1) begin : g_x
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          x_q[j] <= x_in;
        end
      end
    end
  end

  assign byte_o = b_q[Stages-1];

endmodule

### sv/linear_to_srgb_color_encoder_core.sv
// top level of the linear to srgb pixel encoder
`timescale 1ns / 1ps

// linear to srgb pixel encoder
// - input stream: one pixel per transaction, four signed Q.FRAC_BITS channels
//   (red, green, blue, alpha); output stream: four bytes per transaction
// - red, green and blue go through the srgb transfer curve, alpha is scaled
//   linearly; every channel is clamped to 0..255 and truncated
// - each color lane is an eight stage pipelined binary search over a table of
//   255 code thresholds built exactly at elaboration, one result bit per stage
// - throughput: one pixel per clock while the receiver is ready, set by the eight
//   search stages that all run in parallel
// - each stage holds a valid bit and takes new data when it is empty or when
//   the stage after it moves, so bubbles are squeezed out during a stall
// - when the receiver stalls, up to 8 pixels are held in flight and input
//   keeps being accepted until all stages are full; nothing is lost or repeated
// - reset clears all valid bits; the data registers are not reset
module linear_to_srgb_color_encoder_core #(
  parameter int FRAC_BITS = ltsrgb_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // red_linear, green_linear, blue_linear, alpha_linear
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // red_byte, green_byte, blue_byte, alpha_byte
);

  localparam int Stages = ltsrgb_pkg::STAGES;
  localparam int InW    = ltsrgb_pkg::IN_W;
  localparam int ByteW  = ltsrgb_pkg::BYTE_W;
  // alpha product x*255 plus room for the full scale compare
  localparam int AlphaW = InW + ByteW;

  // pipeline control
  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] valid_d;
  logic [Stages:0]   rdy;
  logic [Stages-1:0] en;

  assign rdy[Stages] = m_axis_tready;
  for (genvar j = 0; j < Stages; j++) begin : g_rdy
    // a stage loads when empty or when its contents move on
    assign rdy[j] = ~valid_q[j] | rdy[j+1];
  end
  assign en = rdy[Stages-1:0];

  assign valid_d = (en & {valid_q[Stages-2:0], s_axis_tvalid}) | (~en & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = valid_q[Stages-1];

  // unpack the input transaction, red in the lowest bits
  logic signed [InW-1:0] red_linear;
  logic signed [InW-1:0] green_linear;
  logic signed [InW-1:0] blue_linear;
  logic signed [InW-1:0] alpha_linear;

  assign red_linear   = s_axis_tdata[InW-1:0];
  assign green_linear = s_axis_tdata[2*InW-1:InW];
  assign blue_linear  = s_axis_tdata[3*InW-1:2*InW];
  assign alpha_linear = s_axis_tdata[4*InW-1:3*InW];

  // color lanes
  logic [ByteW-1:0] red_byte;
  logic [ByteW-1:0] green_byte;
  logic [ByteW-1:0] blue_byte;

  ltsrgb_lane #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (red_linear),
    .byte_o (red_byte)
  );

  ltsrgb_lane #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (green_linear),
    .byte_o (green_byte)
  );

  ltsrgb_lane #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (blue_linear),
    .byte_o (blue_byte)
  );

  // alpha is linear: clamp, times 255, truncate; then ride along the pipeline
  localparam logic [AlphaW-1:0] AlphaOne = AlphaW'(1) << FRAC_BITS;

  logic [AlphaW-1:0] alpha_ext;
  logic [AlphaW-1:0] alpha_prod;
  logic [ByteW-1:0]  alpha_in;
  logic [ByteW-1:0]  alpha_q [Stages];

  assign alpha_ext  = {{ByteW{1'b0}}, alpha_linear};
  assign alpha_prod = (alpha_ext << ByteW) - alpha_ext;

  always_comb begin
    if (alpha_linear[InW-1]) begin
      alpha_in = '0;
    end else if (alpha_ext >= AlphaOne) begin
      alpha_in = '1;
    end else begin
      alpha_in = ByteW'(alpha_prod >> FRAC_BITS);
    end
  end

  for (genvar j = 0; j < Stages; j++) begin : g_alpha
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[j]) begin
          alpha_q[j] <= alpha_in;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[j]) begin
          alpha_q[j] <= alpha_q[j-1];
        end
      end
    end
  end

  assign m_axis_tdata = {alpha_q[Stages-1], blue_byte, green_byte, red_byte};

endmodule
